// File: hdl/bbc_pkg.sv
// Shared types, constants and the divisor reciprocal table for the clipped
// 3x3 box blur. No dependencies; used by bbc_mean, bbc_out_fifo and the top level.
`default_nettype none

package bbc_pkg;

  // Register file
  localparam int unsigned CFG_W        = 11;   // width of each config register
  localparam int unsigned CFG_IDX_W    = 1;    // width of the register index
  localparam int unsigned FRAME_WIDTH_RST  = 640;
  localparam int unsigned FRAME_HEIGHT_RST = 480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // Default frame bounds handed to the top level parameters
  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 1024;

  // Pixel and arithmetic widths
  localparam int unsigned CH_W      = 8;          // one color channel
  localparam int unsigned NUM_CH    = 3;
  localparam int unsigned PIX_W     = CH_W * NUM_CH;
  localparam int unsigned SUM_W     = 12;         // 9 * 255 fits
  localparam int unsigned CNT_W     = 4;          // tap count 1..9
  localparam int unsigned RCP_W     = 17;         // reciprocal, up to 2^16
  localparam int unsigned RCP_SHIFT = 16;
  localparam int unsigned PROD_W    = SUM_W + RCP_W;

  // Result queue depth (covers the pipeline latency at full rate)
  localparam int unsigned FIFO_DEPTH = 8;

  // Which taps of the window count for the pixel being averaged
  typedef struct packed {
    logic             top_ok;
    logic             bot_ok;
    logic             left_ok;
    logic             right_ok;
    logic [CNT_W-1:0] cnt;
    logic             last;
  } win_ctl_t;

  // One finished output pixel
  typedef struct packed {
    logic             last;
    logic [PIX_W-1:0] rgb;
  } res_t;

  // ceil(2^16 / n). For sums below 4096 the error term times the sum stays
  // under 2^16, so (sum * recip) >> 16 equals the truncated quotient.
  function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
    logic [RCP_W-1:0] r;
    case (cnt)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd6:    r = 17'd10923;
      4'd9:    r = 17'd7282;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/bbc_row_mem.sv
// Line store: single-clock RAM, one write and one read port, registered read.
// Holds the two previous lines side by side. Depends on nothing.
`default_nettype none

module bbc_row_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned DW    = 48,
  parameter int unsigned AW    = 10
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output      logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered; old data on a same-address collision
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hdl/bbc_mean.sv
// Masked 3x3 sum and reciprocal divide, two register stages.
// Depends on bbc_pkg (win_ctl_t, res_t, recip).
`default_nettype none

module bbc_mean (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  win_vld,
  input  wire bbc_pkg::win_ctl_t                     win_ctl,
  input  wire logic [8:0][bbc_pkg::PIX_W-1:0]        win,
  output      logic                                  res_vld,
  output      bbc_pkg::res_t                         res,
  output      logic [1:0]                            busy
);

  logic [8:0]                                        use_tap;
  logic [2:0]                                        row_ok;
  logic [2:0]                                        col_ok;
  logic [bbc_pkg::NUM_CH-1:0][bbc_pkg::SUM_W-1:0]    sum_nxt;
  logic [bbc_pkg::NUM_CH-1:0][bbc_pkg::SUM_W-1:0]    sum_r;
  logic [bbc_pkg::CNT_W-1:0]                         cnt_r;
  logic                                              last_r;
  logic                                              sum_vld_r;
  logic [bbc_pkg::RCP_W-1:0]                         rcp;
  logic [bbc_pkg::NUM_CH-1:0][bbc_pkg::PROD_W-1:0]   prod;
  bbc_pkg::res_t                                     res_nxt;
  bbc_pkg::res_t                                     res_r;
  logic                                              res_vld_r;

  // Tap mask: row 0 is the upper line, column 0 the leftmost pixel
  always_comb begin
    row_ok = {win_ctl.bot_ok, 1'b1, win_ctl.top_ok};
    col_ok = {win_ctl.right_ok, 1'b1, win_ctl.left_ok};
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        use_tap[i*3 + j] = row_ok[i] & col_ok[j];
      end
    end
  end

  // Per-channel masked sum
  always_comb begin
    for (int ch = 0; ch < bbc_pkg::NUM_CH; ch++) begin
      sum_nxt[ch] = '0;
      for (int k = 0; k < 9; k++) begin
        if (use_tap[k]) begin
          sum_nxt[ch] = sum_nxt[ch]
                      + bbc_pkg::SUM_W'(win[k][ch*bbc_pkg::CH_W +: bbc_pkg::CH_W]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_vld_r <= 1'b0;
    end else begin
      sum_vld_r <= win_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (win_vld) begin
      sum_r  <= sum_nxt;
      cnt_r  <= win_ctl.cnt;
      last_r <= win_ctl.last;
    end
  end

  // Divide by the tap count: multiply by reciprocal, keep the upper bits
  always_comb begin
    rcp = bbc_pkg::recip(cnt_r);
    for (int ch = 0; ch < bbc_pkg::NUM_CH; ch++) begin
      prod[ch] = bbc_pkg::PROD_W'(sum_r[ch]) * bbc_pkg::PROD_W'(rcp);
      res_nxt.rgb[ch*bbc_pkg::CH_W +: bbc_pkg::CH_W] =
        prod[ch][bbc_pkg::RCP_SHIFT +: bbc_pkg::CH_W];
    end
    res_nxt.last = last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else begin
      res_vld_r <= sum_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_vld_r) begin
      res_r <= res_nxt;
    end
  end

  assign res_vld = res_vld_r;
  assign res     = res_r;
  assign busy    = 2'(sum_vld_r) + 2'(res_vld_r);

  // A valid sum never exceeds 255 per counted tap
  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sum_vld_r |-> (sum_r[0] <= 12'd255 * 12'(cnt_r)) &&
                  (sum_r[1] <= 12'd255 * 12'(cnt_r)) &&
                  (sum_r[2] <= 12'd255 * 12'(cnt_r)))
    else $error("bbc_mean: channel sum above its tap count bound");

  // Tap count is one of the clipped window sizes
  a_cnt_legal: assert property (@(posedge clk) disable iff (!rst_n)
    sum_vld_r |-> (cnt_r == 4'd1) || (cnt_r == 4'd2) || (cnt_r == 4'd3) ||
                  (cnt_r == 4'd4) || (cnt_r == 4'd6) || (cnt_r == 4'd9))
    else $error("bbc_mean: illegal tap count");

  // Quotient fits in one channel, nothing lost above the kept bits
  a_quot_fits: assert property (@(posedge clk) disable iff (!rst_n)
    sum_vld_r |-> (prod[0][bbc_pkg::PROD_W-1:bbc_pkg::RCP_SHIFT+bbc_pkg::CH_W] == '0) &&
                  (prod[1][bbc_pkg::PROD_W-1:bbc_pkg::RCP_SHIFT+bbc_pkg::CH_W] == '0) &&
                  (prod[2][bbc_pkg::PROD_W-1:bbc_pkg::RCP_SHIFT+bbc_pkg::CH_W] == '0))
    else $error("bbc_mean: quotient overflow");

endmodule

`default_nettype wire

// File: hdl/bbc_out_fifo.sv
// Small result queue in flip-flops that decouples the pipeline from the
// output stream. Depends on bbc_pkg (res_t).
`default_nettype none

module bbc_out_fifo #(
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         push,
  input  wire bbc_pkg::res_t                din,
  output      logic                         out_valid,
  input  wire logic                         out_ready,
  output      bbc_pkg::res_t                dout,
  output      logic [$clog2(DEPTH+1)-1:0]   cnt
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH+1);

  bbc_pkg::res_t   mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   cnt_r;
  logic            pop;

  assign pop = out_valid && out_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH-1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH-1)) ? '0 : rd_ptr_r + PW'(1);
      end
      cnt_r <= cnt_r + CW'(push) - CW'(pop);
    end
  end

  assign out_valid = (cnt_r != '0);
  assign dout      = mem_r[rd_ptr_r];
  assign cnt       = cnt_r;

endmodule

`default_nettype wire

// File: hdl/box_blur_3x3_clipped.sv
// Top level of the clipped 3x3 box blur: position tracking, line store
// read-modify-write and the tap window. Depends on bbc_pkg, bbc_row_mem,
// bbc_mean and bbc_out_fifo.
//
// Takes RGB888 pixels in raster order on the in_ stream and gives each
// pixel's per-channel 3x3 average on the out_ stream, leaving out neighbors
// outside the frame and dividing (truncating) by the count of those inside.
// A result leaves one row plus one pixel of input after its pixel, so after
// the last pixel the host sends frame_width+1 items with in_tuser set to
// drain the frame; out_tlast marks the frame's last result. The two previous
// lines live in one 48-bit wide line store, read at the pixel's column and
// written back the following cycle, with a bypass when two consecutive
// transactions hit the same column. One pixel per clock is accepted as long
// as the 8-entry result queue has room; a result passes stage 1, the window
// register and both mean stages before it is queued. The line store needs
// no clearing pass after reset. The user writes frame_width and frame_height
// on the cfg_ port while the stream is idle; the block does not enforce it.
// Zero counts as 1 and values above MAX_WIDTH or MAX_HEIGHT saturate.
`default_nettype none

module box_blur_3x3_clipped #(
  parameter int unsigned MAX_WIDTH  = bbc_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = bbc_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Input stream
  input  wire logic                           in_tvalid,
  output      logic                           in_tready,
  input  wire logic [bbc_pkg::PIX_W-1:0]      in_tdata,  // [7:0] red_in, [15:8] green_in,
                                                        // [23:16] blue_in
  input  wire logic                           in_tuser,  // [0] is_padding
  // Output stream
  output      logic                           out_tvalid,
  input  wire logic                           out_tready,
  output      logic [bbc_pkg::PIX_W-1:0]      out_tdata, // [7:0] red_out, [15:8] green_out,
                                                        // [23:16] blue_out
  output      logic                           out_tlast, // frame_end
  // Configuration write
  input  wire logic                           cfg_valid,
  output      logic                           cfg_ready,
  input  wire logic [bbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bbc_pkg::CFG_W-1:0]      cfg_data
);

  localparam int unsigned AW  = $clog2(MAX_WIDTH);       // column address
  localparam int unsigned WW  = $clog2(MAX_WIDTH + 1);   // width value
  localparam int unsigned HW  = $clog2(MAX_HEIGHT + 1);  // height value
  localparam int unsigned RW  = $clog2(MAX_HEIGHT + 4);  // row position
  localparam int unsigned XW  = (bbc_pkg::CFG_W > WW) ? bbc_pkg::CFG_W : WW;
  localparam int unsigned XH  = (bbc_pkg::CFG_W > HW) ? bbc_pkg::CFG_W : HW;
  localparam int unsigned PXW = bbc_pkg::PIX_W;
  localparam int unsigned QCW = $clog2(bbc_pkg::FIFO_DEPTH + 1);
  localparam int unsigned TCW = QCW + 1;

  // Configuration registers
  logic [bbc_pkg::CFG_W-1:0] frame_width_r;
  logic [bbc_pkg::CFG_W-1:0] frame_height_r;

  // Position of the next input
  logic [AW-1:0]   cc_r, cc_nxt;
  logic [RW-1:0]   rc_r, rc_nxt;

  // Position logic
  logic [XW-1:0]   fw_ext;
  logic [XH-1:0]   fh_ext;
  logic [WW-1:0]   w;
  logic [HW-1:0]   h;
  logic [RW-1:0]   hx;
  logic            wrap0, restart, col_pos, emit_a, emit, step_end, last;
  logic [AW-1:0]   cc_b, cc1, oc;
  logic [RW-1:0]   rc_b, rc1, orow;
  logic [1:0]      nr, nc;
  logic            accept;
  logic            fwd;
  logic [PXW-1:0]  pix;
  bbc_pkg::win_ctl_t ctl;

  // Stage 1: line store data returns, write-back and window shift
  logic                   s1_valid_r;
  logic [AW-1:0]          s1_cc_r;
  logic [PXW-1:0]         s1_pix_r;
  logic                   s1_fwd_r;
  logic                   s1_emit_r;
  bbc_pkg::win_ctl_t      s1_ctl_r;
  logic [2*PXW-1:0]       rd_data;
  logic [PXW-1:0]         eff_up, eff_lo;
  logic [PXW-1:0]         fwd_lo_r, fwd_pix_r;
  logic [8:0][PXW-1:0]    win_r, win_nxt;
  logic                   win_vld_r;
  bbc_pkg::win_ctl_t      win_ctl_r;

  // Back end
  logic                   res_vld;
  bbc_pkg::res_t          res;
  bbc_pkg::res_t          q_dout;
  logic [1:0]             mean_busy;
  logic [QCW-1:0]         q_cnt;
  logic [2:0]             inflight;
  logic [TCW-1:0]         credit_used;

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= bbc_pkg::CFG_W'(bbc_pkg::FRAME_WIDTH_RST);
      frame_height_r <= bbc_pkg::CFG_W'(bbc_pkg::FRAME_HEIGHT_RST);
    end else if (cfg_valid) begin
      case (bbc_pkg::cfg_reg_t'(cfg_index))
        bbc_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        bbc_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp frame size to 1..MAX
  always_comb begin
    fw_ext = XW'(frame_width_r);
    fh_ext = XH'(frame_height_r);
    if (fw_ext == '0) begin
      w = WW'(1);
    end else if (fw_ext > XW'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(fw_ext);
    end
    if (fh_ext == '0) begin
      h = HW'(1);
    end else if (fh_ext > XH'(MAX_HEIGHT)) begin
      h = HW'(MAX_HEIGHT);
    end else begin
      h = HW'(fh_ext);
    end
    hx = RW'(h);
  end

  // Normalize position, find the output pixel and its clipping
  always_comb begin
    wrap0   = (WW'(cc_r) >= w);
    cc_b    = wrap0 ? '0 : cc_r;
    rc_b    = wrap0 ? rc_r + RW'(1) : rc_r;
    restart = (rc_b > hx + RW'(1)) || ((rc_b == hx + RW'(1)) && (cc_b != '0));
    cc1     = restart ? '0 : cc_b;
    rc1     = restart ? '0 : rc_b;

    // Output trails by one row and one pixel; at column zero it is the end of the row before that
    col_pos = (cc1 != '0);
    if (col_pos) begin
      oc     = cc1 - AW'(1);
      orow   = rc1 - RW'(1);
      emit_a = (rc1 >= RW'(1));
    end else begin
      oc     = AW'(w - WW'(1));
      orow   = rc1 - RW'(2);
      emit_a = (rc1 >= RW'(2));
    end
    emit = emit_a && (orow < hx);

    ctl.top_ok   = (orow != '0);
    ctl.bot_ok   = (orow + RW'(1) < hx);
    ctl.left_ok  = (oc != '0);
    ctl.right_ok = (WW'(oc) + WW'(1) < w);
    nr           = 2'd1 + 2'(ctl.top_ok) + 2'(ctl.bot_ok);
    nc           = 2'd1 + 2'(ctl.left_ok) + 2'(ctl.right_ok);
    ctl.cnt      = bbc_pkg::CNT_W'(nr) * bbc_pkg::CNT_W'(nc);
    last         = (orow == hx - RW'(1)) && (WW'(oc) == w - WW'(1));
    ctl.last     = last;

    // Advance
    step_end = (WW'(cc1) + WW'(1) >= w);
    if (emit && last) begin
      cc_nxt = '0;
      rc_nxt = '0;
    end else if (step_end) begin
      cc_nxt = '0;
      rc_nxt = rc1 + RW'(1);
    end else begin
      cc_nxt = cc1 + AW'(1);
      rc_nxt = rc1;
    end
  end

  assign accept = in_tvalid && in_tready;
  assign pix    = in_tuser ? '0 : in_tdata;
  // Previous transaction writes this column at the same edge we read it
  assign fwd    = s1_valid_r && (s1_cc_r == cc1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r <= '0;
      rc_r <= '0;
    end else if (accept) begin
      cc_r <= cc_nxt;
      rc_r <= rc_nxt;
    end
  end

  // Line store: {upper, lower} per column
  bbc_row_mem #(
    .DEPTH (MAX_WIDTH),
    .DW    (2*PXW),
    .AW    (AW)
  ) u_row_mem (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_cc_r),
    .wdata ({eff_lo, s1_pix_r}),
    .re    (accept),
    .raddr (cc1),
    .rdata (rd_data)
  );

  // Stage 1 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cc_r   <= cc1;
      s1_pix_r  <= pix;
      s1_fwd_r  <= fwd;
      s1_emit_r <= emit;
      s1_ctl_r  <= ctl;
    end
  end

  // Bypass the line store on a same-column back-to-back access
  assign eff_up = s1_fwd_r ? fwd_lo_r  : rd_data[2*PXW-1:PXW];
  assign eff_lo = s1_fwd_r ? fwd_pix_r : rd_data[PXW-1:0];

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      fwd_lo_r  <= eff_lo;
      fwd_pix_r <= s1_pix_r;
    end
  end

  // Window shift: columns move left, new column enters on the right
  always_comb begin
    win_nxt = win_r;
    for (int i = 0; i < 3; i++) begin
      win_nxt[i*3]     = win_r[i*3 + 1];
      win_nxt[i*3 + 1] = win_r[i*3 + 2];
    end
    win_nxt[2] = eff_up;
    win_nxt[5] = eff_lo;
    win_nxt[8] = s1_pix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r     <= '0;
      win_vld_r <= 1'b0;
    end else begin
      win_vld_r <= s1_valid_r && s1_emit_r;
      if (s1_valid_r) begin
        win_r <= win_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      win_ctl_r <= s1_ctl_r;
    end
  end

  // Sum and divide
  bbc_mean u_mean (
    .clk     (clk),
    .rst_n   (rst_n),
    .win_vld (win_vld_r),
    .win_ctl (win_ctl_r),
    .win     (win_r),
    .res_vld (res_vld),
    .res     (res),
    .busy    (mean_busy)
  );

  // Result queue
  bbc_out_fifo #(
    .DEPTH (bbc_pkg::FIFO_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_vld),
    .din       (res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .dout      (q_dout),
    .cnt       (q_cnt)
  );

  assign out_tdata = q_dout.rgb;
  assign out_tlast = q_dout.last;

  // Accept only while every transaction in flight has a queue slot
  assign inflight    = 3'(s1_valid_r) + 3'(win_vld_r) + 3'(mean_busy);
  assign credit_used = TCW'(q_cnt) + TCW'(inflight);
  assign in_tready   = (credit_used < TCW'(bbc_pkg::FIFO_DEPTH));

  // Queue plus pipeline never exceed the queue depth
  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    credit_used <= TCW'(bbc_pkg::FIFO_DEPTH))
    else $error("box_blur_3x3_clipped: result queue overcommitted");

  // A bypass only follows a transaction that was in stage 1 the cycle before
  a_fwd_src: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_fwd_r) |-> $past(s1_valid_r))
    else $error("box_blur_3x3_clipped: bypass without a preceding write");

  // The frame's last result sends the position back to the first pixel
  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && emit && last) |=> (cc_r == '0) && (rc_r == '0))
    else $error("box_blur_3x3_clipped: position not reset at frame end");

endmodule

`default_nettype wire
